/* hw/rtl/fac_pkg.sv */
// ----------------------------------------------------------------------------
// Flap attitude controller package
// Shared constants, types and helper functions of the flap controller.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int ANG_PI16       = 205887;
  localparam int TWENTY_DEG     = 1430;
  localparam int NINETY_DEG     = 6434;
  localparam int FF_ONE         = 16384;
  localparam int BOTTOM_NEUTRAL = 0;

  localparam int AXIS_W       = 32;
  localparam int CORDIC_W     = 36;
  localparam int ANG_ACC_W    = 21;
  localparam int ANG_W        = 16;
  localparam int CORDIC_STEPS = 17;
  localparam int SQRT_STEPS   = 32;
  localparam int SQRT_STAGES  = SQRT_STEPS / 2;

  localparam int AXES_LAT   = 2;
  localparam int NORM_LAT   = 2 + SQRT_STAGES;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int MIX_LAT    = 5;
  localparam int SIDE_LAT   = AXES_LAT + NORM_LAT + CORDIC_LAT;

  typedef enum logic [2:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_AZ_GAIN     = 3'd1,
    CFG_PITCH_GAIN  = 3'd2,
    CFG_AZ_LIMIT    = 3'd3,
    CFG_RATE_GAIN_X = 3'd4,
    CFG_RATE_GAIN_Y = 3'd5,
    CFG_RATE_GAIN_Z = 3'd6,
    CFG_TOP_NEUTRAL = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_STABILIZE = 2'd0,
    MODE_UPRIGHT   = 2'd1,
    MODE_ASCENT    = 2'd2
  } mode_t;

  typedef struct packed {
    logic        [13:0] threshold;
    logic signed [15:0] az_gain;
    logic signed [15:0] pitch_gain;
    logic        [14:0] az_limit;
    logic signed [15:0] rate_gain_x;
    logic signed [15:0] rate_gain_y;
    logic signed [15:0] rate_gain_z;
    logic signed [14:0] top_neutral;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [1:0]  flight_mode;
    logic signed [14:0] azimuth_setpoint;
    logic signed [14:0] pitch_setpoint;
    logic               extend_on_ascent;
  } side_t;

  function automatic logic signed [ANG_ACC_W-1:0] atan_val(input int i);
    logic signed [ANG_ACC_W-1:0] v;
    case (i)
      0:       v = 21'sd51472;
      1:       v = 21'sd30386;
      2:       v = 21'sd16055;
      3:       v = 21'sd8150;
      4:       v = 21'sd4091;
      5:       v = 21'sd2047;
      6:       v = 21'sd1024;
      7:       v = 21'sd512;
      8:       v = 21'sd256;
      9:       v = 21'sd128;
      10:      v = 21'sd64;
      11:      v = 21'sd32;
      12:      v = 21'sd16;
      13:      v = 21'sd8;
      14:      v = 21'sd4;
      15:      v = 21'sd2;
      16:      v = 21'sd1;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/flap_attitude_controller.sv */
// ----------------------------------------------------------------------------
// Flap attitude controller
// The path from input to result has 2 axis, 18 norm, 19 CORDIC and 5 mixer
// stages. Throughput is one transaction per cycle unless the output stalls.
// A stalled output freezes every pipeline stage, so nothing is lost.
// Synchronous active-low reset clears the valid bits and the configuration
// registers to 0; the data registers are not reset.
// ----------------------------------------------------------------------------
module flap_attitude_controller (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
  // azimuth_setpoint, pitch_setpoint, two zero bits
  input  logic [143:0] in_tdata,
  // flight_mode, extend_on_ascent
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // flap_top_left, flap_top_right, flap_bottom_left, flap_bottom_right
  output logic [63:0]  out_tdata,
  // flaps_enabled
  output logic         out_tuser,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int AW = fac_pkg::AXIS_W;

  fac_pkg::cfg_t  cfg_r;
  fac_pkg::side_t side_in;
  fac_pkg::side_t side_r [fac_pkg::SIDE_LAT];
  logic           adv;

  logic                 ax_vld;
  logic signed [AW-1:0] ax0, ax1, ax2, az0, az1, az2;
  logic signed [AW-1:0] ax2_d_r [fac_pkg::NORM_LAT];
  logic signed [AW-1:0] az0_d_r [fac_pkg::NORM_LAT];
  logic signed [AW-1:0] az1_d_r [fac_pkg::NORM_LAT];
  logic signed [AW-1:0] az2_d_r;
  logic signed [AW-1:0] az2_dl_r [fac_pkg::NORM_LAT-1];
  logic                 nx_vld;
  logic signed [AW-1:0] nx, nz;
  logic                 cb_vld;
  logic signed [fac_pkg::ANG_W-1:0] belly, azimuth, pitch;
  logic                 mix_vld;
  logic signed [15:0]   ftl, ftr, fbl, fbr;

  assign adv        = !mix_vld || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = mix_vld;
  assign out_tdata  = {fbr, fbl, ftr, ftl};
  assign out_tuser  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (fac_pkg::cfg_idx_t'(cfg_addr))
        fac_pkg::CFG_THRESHOLD:   cfg_r.threshold   <= cfg_wdata[13:0];
        fac_pkg::CFG_AZ_GAIN:     cfg_r.az_gain     <= cfg_wdata;
        fac_pkg::CFG_PITCH_GAIN:  cfg_r.pitch_gain  <= cfg_wdata;
        fac_pkg::CFG_AZ_LIMIT:    cfg_r.az_limit    <= cfg_wdata[14:0];
        fac_pkg::CFG_RATE_GAIN_X: cfg_r.rate_gain_x <= cfg_wdata;
        fac_pkg::CFG_RATE_GAIN_Y: cfg_r.rate_gain_y <= cfg_wdata;
        fac_pkg::CFG_RATE_GAIN_Z: cfg_r.rate_gain_z <= cfg_wdata;
        fac_pkg::CFG_TOP_NEUTRAL: cfg_r.top_neutral <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    side_in.rate_x           = in_tdata[79:64];
    side_in.rate_y           = in_tdata[95:80];
    side_in.rate_z           = in_tdata[111:96];
    side_in.azimuth_setpoint = in_tdata[126:112];
    side_in.pitch_setpoint   = in_tdata[141:127];
    side_in.flight_mode      = in_tuser[1:0];
    side_in.extend_on_ascent = in_tuser[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < fac_pkg::SIDE_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
      ax2_d_r[0] <= ax2;
      az0_d_r[0] <= az0;
      az1_d_r[0] <= az1;
      for (int i = 1; i < fac_pkg::NORM_LAT; i++) begin
        ax2_d_r[i] <= ax2_d_r[i-1];
        az0_d_r[i] <= az0_d_r[i-1];
        az1_d_r[i] <= az1_d_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      az2_dl_r[0] <= az2;
      for (int i = 1; i < fac_pkg::NORM_LAT - 1; i++) begin
        az2_dl_r[i] <= az2_dl_r[i-1];
      end
      az2_d_r <= az2_dl_r[fac_pkg::NORM_LAT-2];
    end
  end

  fac_axes u_axes (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_tvalid),
    .qw      (in_tdata[15:0]),
    .qx      (in_tdata[31:16]),
    .qy      (in_tdata[47:32]),
    .qz      (in_tdata[63:48]),
    .out_vld (ax_vld),
    .ax0     (ax0),
    .ax1     (ax1),
    .ax2     (ax2),
    .az0     (az0),
    .az1     (az1),
    .az2     (az2)
  );

  fac_norm u_norm_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (ax_vld),
    .a       (ax0),
    .b       (ax1),
    .out_vld (nx_vld),
    .norm    (nx)
  );

  fac_norm u_norm_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (ax_vld),
    .a       (az0),
    .b       (az1),
    .out_vld (),
    .norm    (nz)
  );

  fac_cordic u_belly (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (nx_vld),
    .y_in    (nx),
    .x_in    (ax2_d_r[fac_pkg::NORM_LAT-1]),
    .out_vld (cb_vld),
    .angle   (belly)
  );

  fac_cordic u_azimuth (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (nx_vld),
    .y_in    (az1_d_r[fac_pkg::NORM_LAT-1]),
    .x_in    (az0_d_r[fac_pkg::NORM_LAT-1]),
    .out_vld (),
    .angle   (azimuth)
  );

  fac_cordic u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (nx_vld),
    .y_in    (az2_d_r),
    .x_in    (nz),
    .out_vld (),
    .angle   (pitch)
  );

  fac_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (cb_vld),
    .belly   (belly),
    .azimuth (azimuth),
    .pitch   (pitch),
    .side    (side_r[fac_pkg::SIDE_LAT-1]),
    .cfg     (cfg_r),
    .out_vld (mix_vld),
    .flap_tl (ftl),
    .flap_tr (ftr),
    .flap_bl (fbl),
    .flap_br (fbr)
  );

endmodule

/* hw/rtl/fac_axes.sv */
// ----------------------------------------------------------------------------
// Body axis stage
// Forms the body X and body Z axes in the reference frame from the quaternion.
// ----------------------------------------------------------------------------
module fac_axes (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_vld,
  input  logic signed [15:0]                     qw,
  input  logic signed [15:0]                     qx,
  input  logic signed [15:0]                     qy,
  input  logic signed [15:0]                     qz,
  output logic                                   out_vld,
  output logic signed [fac_pkg::AXIS_W-1:0]      ax0,
  output logic signed [fac_pkg::AXIS_W-1:0]      ax1,
  output logic signed [fac_pkg::AXIS_W-1:0]      ax2,
  output logic signed [fac_pkg::AXIS_W-1:0]      az0,
  output logic signed [fac_pkg::AXIS_W-1:0]      az1,
  output logic signed [fac_pkg::AXIS_W-1:0]      az2
);

  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic               vld1_r, vld2_r;
  logic signed [33:0] sx0, sz2;
  logic signed [32:0] sx1, sx2, sz0, sz1;
  logic signed [fac_pkg::AXIS_W-1:0] ax0_r, ax1_r, ax2_r, az0_r, az1_r, az2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ww_r <= qw * qw;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      zz_r <= qz * qz;
      xy_r <= qx * qy;
      wz_r <= qw * qz;
      xz_r <= qx * qz;
      wy_r <= qw * qy;
      yz_r <= qy * qz;
      wx_r <= qw * qx;
    end
  end

  always_comb begin
    sx0 = 34'(ww_r) + 34'(xx_r) - 34'(yy_r) - 34'(zz_r);
    sz2 = 34'(ww_r) - 34'(xx_r) - 34'(yy_r) + 34'(zz_r);
    sx1 = 33'(xy_r) - 33'(wz_r);
    sx2 = 33'(xz_r) + 33'(wy_r);
    sz0 = 33'(xz_r) - 33'(wy_r);
    sz1 = 33'(yz_r) + 33'(wx_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0_r <= fac_pkg::AXIS_W'(sx0 >>> 2);
      ax1_r <= fac_pkg::AXIS_W'(sx1 >>> 1);
      ax2_r <= fac_pkg::AXIS_W'(sx2 >>> 1);
      az0_r <= fac_pkg::AXIS_W'(sz0 >>> 1);
      az1_r <= fac_pkg::AXIS_W'(sz1 >>> 1);
      az2_r <= fac_pkg::AXIS_W'(sz2 >>> 2);
    end
  end

  assign out_vld = vld2_r;
  assign ax0     = ax0_r;
  assign ax1     = ax1_r;
  assign ax2     = ax2_r;
  assign az0     = az0_r;
  assign az1     = az1_r;
  assign az2     = az2_r;

endmodule

/* hw/rtl/fac_norm.sv */
// ----------------------------------------------------------------------------
// Vector norm unit
// Pipelined floor square root of a^2 + b^2, two result bits per stage.
// ----------------------------------------------------------------------------
module fac_norm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic signed [fac_pkg::AXIS_W-1:0] a,
  input  logic signed [fac_pkg::AXIS_W-1:0] b,
  output logic                              out_vld,
  output logic signed [fac_pkg::AXIS_W-1:0] norm
);

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  function automatic sq_t sqrt_step(input sq_t s, input logic [63:0] bit_w);
    sq_t o;
    o = s;
    if (s.v >= s.r + bit_w) begin
      o.v = s.v - (s.r + bit_w);
      o.r = (s.r >> 1) + bit_w;
    end else begin
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  logic [63:0] sqa_r, sqb_r;
  sq_t         st_r [fac_pkg::SQRT_STAGES+1];
  logic        vld_r [fac_pkg::NORM_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fac_pkg::NORM_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < fac_pkg::NORM_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqa_r    <= 64'(a) * 64'(a);
      sqb_r    <= 64'(b) * 64'(b);
      st_r[0]  <= '{v: sqa_r + sqb_r, r: 64'd0};
    end
  end

  for (genvar s = 0; s < fac_pkg::SQRT_STAGES; s++) begin : g_stage
    localparam logic [63:0] BIT_HI = 64'd1 << (2 * (fac_pkg::SQRT_STEPS - 1 - 2 * s));
    localparam logic [63:0] BIT_LO = 64'd1 << (2 * (fac_pkg::SQRT_STEPS - 2 - 2 * s));
    sq_t nxt;
    always_comb begin
      nxt = sqrt_step(sqrt_step(st_r[s], BIT_HI), BIT_LO);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[s+1] <= nxt;
      end
    end
  end

  assign out_vld = vld_r[fac_pkg::NORM_LAT-1];
  assign norm    = fac_pkg::AXIS_W'(st_r[fac_pkg::SQRT_STAGES].r);

endmodule

/* hw/rtl/fac_cordic.sv */
// ----------------------------------------------------------------------------
// CORDIC arctangent
// Pipelined atan2 in vectoring mode, one rotation per stage, Q3.12 result.
// ----------------------------------------------------------------------------
module fac_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic signed [fac_pkg::AXIS_W-1:0] y_in,
  input  logic signed [fac_pkg::AXIS_W-1:0] x_in,
  output logic                              out_vld,
  output logic signed [fac_pkg::ANG_W-1:0]  angle
);

  localparam int N  = fac_pkg::CORDIC_STEPS;
  localparam int CW = fac_pkg::CORDIC_W;
  localparam int AW = fac_pkg::ANG_ACC_W;

  logic signed [CW-1:0] x_r [N+1];
  logic signed [CW-1:0] y_r [N+1];
  logic signed [AW-1:0] z_r [N+1];
  logic                 zero_r [N+1];
  logic                 vld_r [fac_pkg::CORDIC_LAT];
  logic signed [fac_pkg::ANG_W-1:0] angle_r;

  logic signed [CW-1:0] xs, ys;
  logic signed [AW-1:0] base;
  logic signed [AW-1:0] zr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fac_pkg::CORDIC_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < fac_pkg::CORDIC_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_comb begin
    xs   = CW'(x_in);
    ys   = CW'(y_in);
    base = '0;
    if (x_in < 0) begin
      xs   = -xs;
      ys   = -ys;
      base = (y_in >= 0) ? AW'(fac_pkg::ANG_PI16) : -AW'(fac_pkg::ANG_PI16);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= xs;
      y_r[0]    <= ys;
      z_r[0]    <= base;
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [AW-1:0] ATAN = fac_pkg::atan_val(i);
    always_ff @(posedge clk) begin
      if (adv) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end
      end
    end
  end

  assign zr = (z_r[N] + AW'(8)) >>> 4;

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r <= zero_r[N] ? '0 : fac_pkg::ANG_W'(zr);
    end
  end

  assign out_vld = vld_r[fac_pkg::CORDIC_LAT-1];
  assign angle   = angle_r;

endmodule

/* hw/rtl/fac_mix.sv */
// ----------------------------------------------------------------------------
// Flap mixer
// Flap factor, proportional and damping terms, flap mixing and mode selection.
// ----------------------------------------------------------------------------
module fac_mix (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_vld,
  input  logic signed [fac_pkg::ANG_W-1:0] belly,
  input  logic signed [fac_pkg::ANG_W-1:0] azimuth,
  input  logic signed [fac_pkg::ANG_W-1:0] pitch,
  input  fac_pkg::side_t                   side,
  input  fac_pkg::cfg_t                    cfg,
  output logic                             out_vld,
  output logic signed [15:0]               flap_tl,
  output logic signed [15:0]               flap_tr,
  output logic signed [15:0]               flap_bl,
  output logic signed [15:0]               flap_br
);

  localparam logic [21:0] FF_RECIP = 22'((64'd1 << 32) / fac_pkg::TWENTY_DEG);

  logic vld_r [fac_pkg::MIX_LAT];
  logic [1:0] mode1_r, mode2_r, mode3_r, mode4_r;
  logic       ext1_r, ext2_r, ext3_r, ext4_r;

  // Stage 1
  logic signed [16:0] d;
  logic [24:0]        n;
  logic [24:0]        n1_r;
  logic [46:0]        qp1_r;
  logic               pos1_r, big1_r;
  logic signed [32:0] eaz1_r, ept1_r;
  logic signed [31:0] rpx1_r, rpy1_r, rpz1_r;
  logic signed [16:0] eaz, ept;

  // Stage 2
  logic signed [33:0] lim_s, eaz_c;
  logic [14:0]        q2_r;
  logic [24:0]        n2_r;
  logic               pos2_r, big2_r;
  logic signed [35:0] u0_r, u1_r, u2_r;

  // Stage 3
  logic [24:0]        rem;
  logic [14:0]        f;
  logic [14:0]        ff3_r;
  logic signed [37:0] stl3_r, str3_r, sbl3_r, sbr3_r;

  // Stage 4
  logic signed [53:0] ptl4_r, ptr4_r, pbl4_r, pbr4_r;

  // Stage 5
  logic signed [53:0] rtl, rtr, rbl, rbr;
  logic signed [33:0] vtl, vtr, vbl, vbr;
  logic signed [15:0] otl, otr, obl, obr;
  logic signed [15:0] tl5_r, tr5_r, bl5_r, br5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fac_pkg::MIX_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < fac_pkg::MIX_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_comb begin
    d   = 17'(belly) - $signed({3'b000, cfg.threshold});
    n   = {d[10:0], 14'd0};
    eaz = 17'(side.azimuth_setpoint) - 17'(azimuth);
    ept = 17'(side.pitch_setpoint) - 17'(pitch);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r    <= n;
      qp1_r   <= 47'(n) * 47'(FF_RECIP);
      pos1_r  <= d > 0;
      big1_r  <= d >= 17'(fac_pkg::TWENTY_DEG);
      eaz1_r  <= 33'(eaz) * 33'(cfg.az_gain);
      ept1_r  <= 33'(ept) * 33'(cfg.pitch_gain);
      rpx1_r  <= side.rate_x * cfg.rate_gain_x;
      rpy1_r  <= side.rate_y * cfg.rate_gain_y;
      rpz1_r  <= side.rate_z * cfg.rate_gain_z;
      mode1_r <= side.flight_mode;
      ext1_r  <= side.extend_on_ascent;
    end
  end

  always_comb begin
    lim_s = $signed({11'd0, cfg.az_limit, 8'd0});
    eaz_c = 34'(eaz1_r);
    if (eaz_c > lim_s) begin
      eaz_c = lim_s;
    end else if (eaz_c < -lim_s) begin
      eaz_c = -lim_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_r    <= qp1_r[46:32];
      n2_r    <= n1_r;
      pos2_r  <= pos1_r;
      big2_r  <= big1_r;
      u0_r    <= 36'(eaz_c) - (36'(rpx1_r) <<< 2);
      u1_r    <= 36'(ept1_r) - (36'(rpy1_r) <<< 2);
      u2_r    <= -(36'(rpz1_r) <<< 2);
      mode2_r <= mode1_r;
      ext2_r  <= ext1_r;
    end
  end

  always_comb begin
    rem = n2_r - 25'(25'(q2_r) * 25'(fac_pkg::TWENTY_DEG));
    f   = (rem >= 25'(fac_pkg::TWENTY_DEG)) ? q2_r + 15'd1 : q2_r;
    if (!pos2_r) begin
      f = '0;
    end else if (big2_r || f > 15'(fac_pkg::FF_ONE)) begin
      f = 15'(fac_pkg::FF_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ff3_r   <= 15'(fac_pkg::FF_ONE) - f;
      stl3_r  <= -38'(u0_r) - 38'(u1_r) + 38'(u2_r);
      str3_r  <= 38'(u0_r) - 38'(u1_r) - 38'(u2_r);
      sbl3_r  <= 38'(u0_r) + 38'(u1_r) + 38'(u2_r);
      sbr3_r  <= -38'(u0_r) + 38'(u1_r) - 38'(u2_r);
      mode3_r <= mode2_r;
      ext3_r  <= ext2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ptl4_r  <= 54'(stl3_r) * 54'($signed({1'b0, ff3_r}));
      ptr4_r  <= 54'(str3_r) * 54'($signed({1'b0, ff3_r}));
      pbl4_r  <= 54'(sbl3_r) * 54'($signed({1'b0, ff3_r}));
      pbr4_r  <= 54'(sbr3_r) * 54'($signed({1'b0, ff3_r}));
      mode4_r <= mode3_r;
      ext4_r  <= ext3_r;
    end
  end

  always_comb begin
    rtl = (ptl4_r + 54'sd2097152) >>> 22;
    rtr = (ptr4_r + 54'sd2097152) >>> 22;
    rbl = (pbl4_r + 54'sd2097152) >>> 22;
    rbr = (pbr4_r + 54'sd2097152) >>> 22;
    vtl = 34'(rtl) + 34'(cfg.top_neutral);
    vtr = 34'(rtr) + 34'(cfg.top_neutral);
    vbl = 34'(rbl) + 34'(fac_pkg::BOTTOM_NEUTRAL);
    vbr = 34'(rbr) + 34'(fac_pkg::BOTTOM_NEUTRAL);
    case (fac_pkg::mode_t'(mode4_r))
      fac_pkg::MODE_STABILIZE: begin
        otl = fac_pkg::sat16(vtl);
        otr = fac_pkg::sat16(vtr);
        obl = fac_pkg::sat16(vbl);
        obr = fac_pkg::sat16(vbr);
      end
      fac_pkg::MODE_UPRIGHT: begin
        otl = '0;
        otr = '0;
        obl = 16'(fac_pkg::NINETY_DEG);
        obr = 16'(fac_pkg::NINETY_DEG);
      end
      default: begin
        otl = ext4_r ? '0 : 16'(fac_pkg::NINETY_DEG);
        otr = otl;
        obl = otl;
        obr = otl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tl5_r <= otl;
      tr5_r <= otr;
      bl5_r <= obl;
      br5_r <= obr;
    end
  end

  assign out_vld = vld_r[fac_pkg::MIX_LAT-1];
  assign flap_tl = tl5_r;
  assign flap_tr = tr5_r;
  assign flap_bl = bl5_r;
  assign flap_br = br5_r;

endmodule

/* bench/flap_attitude_controller_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flap attitude controller testbench
// Streams control ticks into the controller with random gaps on both sides,
// predicts each flap result in fixed point and compares the four flap angles
// and the enable flag with the transactions seen at the output.
// ----------------------------------------------------------------------------
module flap_attitude_controller_tb;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [15:0] rx, ry, rz;
    logic [1:0]         mode;
    logic signed [14:0] az_sp, pt_sp;
    logic               ext;
  } tick_t;

  typedef struct {
    logic signed [15:0] tl, tr, bl, br;
    logic               en;
  } flaps_t;

  localparam int LATENCY = 44;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  always #2 clk = ~clk;

  flap_attitude_controller i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  longint threshold, az_gain, pt_gain, az_limit, gain_x, gain_y, gain_z, top_neutral;

  tick_t  tick_queue[$];
  flaps_t flaps_expected[$];
  int errors = 0;
  int ticks_sent = 0;
  int flaps_seen = 0;
  int mode_count[3];
  longint cycles = 0;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vec_len(longint a, longint b);
    return int_sqrt(a * a + b * b);
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, base, dx, dy;
    longint steps[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                          128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    base = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? fac_pkg::ANG_PI16 : -fac_pkg::ANG_PI16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 17; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += steps[i];
      end else begin
        x -= dx; y += dy; z -= steps[i];
      end
    end
    return (base + z + 8) >>> 4;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint fade(longint s, longint ff);
    return (s * ff + (64'sd1 <<< 21)) >>> 22;
  endfunction

  function automatic flaps_t predict_flaps(tick_t t);
    flaps_t r;
    longint w, x, y, z, x0, x1, x2, z0, z1, z2, belly, az, pt, d, f, ff;
    longint u0, u1, u2, lim, tl, tr, bl, br;
    w = t.qw; x = t.qx; y = t.qy; z = t.qz;
    if (t.mode == fac_pkg::MODE_STABILIZE) begin
      x0 = floor_shift(w * w + x * x - y * y - z * z, 2);
      x1 = floor_shift(2 * (x * y - w * z), 2);
      x2 = floor_shift(2 * (x * z + w * y), 2);
      z0 = floor_shift(2 * (x * z - w * y), 2);
      z1 = floor_shift(2 * (y * z + w * x), 2);
      z2 = floor_shift(w * w - x * x - y * y + z * z, 2);
      belly = cordic_angle(vec_len(x0, x1), x2);
      az = cordic_angle(z1, z0);
      pt = cordic_angle(z2, vec_len(z0, z1));
      d = belly - threshold;
      f = 0;
      if (d > 0) begin
        f = (d * fac_pkg::FF_ONE) / fac_pkg::TWENTY_DEG;
        if (f > fac_pkg::FF_ONE) f = fac_pkg::FF_ONE;
      end
      ff = fac_pkg::FF_ONE - f;
      lim = az_limit * 256;
      u0 = (longint'(t.az_sp) - az) * az_gain;
      if (u0 > lim) u0 = lim;
      else if (u0 < -lim) u0 = -lim;
      u1 = (longint'(t.pt_sp) - pt) * pt_gain;
      u0 -= longint'(t.rx) * gain_x * 4;
      u1 -= longint'(t.ry) * gain_y * 4;
      u2 = -(longint'(t.rz) * gain_z * 4);
      tl = top_neutral + fade(-u0 - u1 + u2, ff);
      tr = top_neutral + fade(u0 - u1 - u2, ff);
      bl = fac_pkg::BOTTOM_NEUTRAL + fade(u0 + u1 + u2, ff);
      br = fac_pkg::BOTTOM_NEUTRAL + fade(-u0 + u1 - u2, ff);
    end else if (t.mode == fac_pkg::MODE_UPRIGHT) begin
      tl = 0; tr = 0; bl = fac_pkg::NINETY_DEG; br = fac_pkg::NINETY_DEG;
    end else begin
      tl = t.ext ? 0 : fac_pkg::NINETY_DEG;
      tr = tl; bl = tl; br = tl;
    end
    r.tl = clip16(tl);
    r.tr = clip16(tr);
    r.bl = clip16(bl);
    r.br = clip16(br);
    r.en = 1'b1;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_q14();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int pick;
    pick = $urandom_range(0, 9);
    t.qw = rand_q14(); t.qx = rand_q14(); t.qy = rand_q14(); t.qz = rand_q14();
    if (pick == 0) begin
      t.qw = 16'($urandom()); t.qx = 16'($urandom());
      t.qy = 16'($urandom()); t.qz = 16'($urandom());
    end else if (pick == 1) begin
      t.qx = '0; t.qy = '0;
    end
    t.rx = 16'($urandom()); t.ry = 16'($urandom()); t.rz = 16'($urandom());
    if ($urandom_range(0, 2) != 0) begin
      t.rx = 16'($signed($urandom_range(0, 2000)) - 1000);
      t.ry = 16'($signed($urandom_range(0, 2000)) - 1000);
      t.rz = 16'($signed($urandom_range(0, 2000)) - 1000);
    end
    pick = $urandom_range(0, 9);
    t.mode = pick < 7 ? fac_pkg::MODE_STABILIZE : 2'($urandom_range(1, 3));
    if ($urandom_range(0, 7) == 0) begin
      t.az_sp = 15'($urandom());
      t.pt_sp = 15'($urandom());
    end else begin
      t.az_sp = 15'($signed($urandom_range(0, 25736)) - 12868);
      t.pt_sp = 15'($signed($urandom_range(0, 25736)) - 12868);
    end
    t.ext = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic tick_t make_tick(int qw, int qx, int qy, int qz, int r, int m,
                                      int sp, bit e);
    tick_t t;
    t.qw = 16'(qw); t.qx = 16'(qx); t.qy = 16'(qy); t.qz = 16'(qz);
    t.rx = 16'(r); t.ry = 16'(-r); t.rz = 16'(r);
    t.mode = 2'(m); t.az_sp = 15'(sp); t.pt_sp = 15'(-sp); t.ext = e;
    return t;
  endfunction

  task automatic write_reg(fac_pkg::cfg_idx_t idx, longint value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[15:0];
    case (idx)
      fac_pkg::CFG_THRESHOLD:   threshold = value & 14'h3FFF;
      fac_pkg::CFG_AZ_GAIN:     az_gain = 16'(value);
      fac_pkg::CFG_PITCH_GAIN:  pt_gain = 16'(value);
      fac_pkg::CFG_AZ_LIMIT:    az_limit = value & 15'h7FFF;
      fac_pkg::CFG_RATE_GAIN_X: gain_x = 16'(value);
      fac_pkg::CFG_RATE_GAIN_Y: gain_y = 16'(value);
      fac_pkg::CFG_RATE_GAIN_Z: gain_z = 16'(value);
      default:                  top_neutral = 15'(value);
    endcase
    threshold = threshold & 14'h3FFF;
    az_limit = az_limit & 15'h7FFF;
    az_gain = $signed(16'(az_gain)); pt_gain = $signed(16'(pt_gain));
    gain_x = $signed(16'(gain_x)); gain_y = $signed(16'(gain_y));
    gain_z = $signed(16'(gain_z)); top_neutral = $signed(15'(top_neutral));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_setting(longint th, longint ag, longint pg, longint lim,
                              longint gx, longint gy, longint gz, longint tn);
    write_reg(fac_pkg::CFG_THRESHOLD, th);
    write_reg(fac_pkg::CFG_AZ_GAIN, ag);
    write_reg(fac_pkg::CFG_PITCH_GAIN, pg);
    write_reg(fac_pkg::CFG_AZ_LIMIT, lim);
    write_reg(fac_pkg::CFG_RATE_GAIN_X, gx);
    write_reg(fac_pkg::CFG_RATE_GAIN_Y, gy);
    write_reg(fac_pkg::CFG_RATE_GAIN_Z, gz);
    write_reg(fac_pkg::CFG_TOP_NEUTRAL, tn);
  endtask

  task automatic drain();
    while (tick_queue.size() != 0 || flaps_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) tick_queue.push_back(rand_tick());
    drain();
  endtask

  // Handshakes as seen at the rising edge.
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    out_taken <= out_tvalid && out_tready;
  end

  // Driver: a random gap after each accepted transaction.
  int send_gap = 0;
  always @(negedge clk) begin
    tick_t t;
    logic slot_free;
    if (rst_n) begin
      slot_free = !in_tvalid || in_taken;
      if (in_taken) begin
        send_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (slot_free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          t = tick_queue.pop_front();
          in_tdata <= {2'b00, t.pt_sp, t.az_sp, t.rz, t.ry, t.rx, t.qz, t.qy, t.qx, t.qw};
          in_tuser <= {t.ext, t.mode};
          in_tvalid <= 1'b1;
          flaps_expected.push_back(predict_flaps(t));
          ticks_sent++;
          mode_count[t.mode == 2'd3 ? 2 : t.mode]++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls at random.
  int stall = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        stall = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: compares each output transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      flaps_t exp_f, act;
      act.tl = out_tdata[15:0];
      act.tr = out_tdata[31:16];
      act.bl = out_tdata[47:32];
      act.br = out_tdata[63:48];
      act.en = out_tuser;
      flaps_seen++;
      if (flaps_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h/%b", $time, out_tdata, out_tuser);
      end else begin
        exp_f = flaps_expected.pop_front();
        if (act.tl !== exp_f.tl) begin
          errors++;
          $display("%0t: top_left expected %0d actual %0d", $time, exp_f.tl, act.tl);
        end
        if (act.tr !== exp_f.tr) begin
          errors++;
          $display("%0t: top_right expected %0d actual %0d", $time, exp_f.tr, act.tr);
        end
        if (act.bl !== exp_f.bl) begin
          errors++;
          $display("%0t: bottom_left expected %0d actual %0d", $time, exp_f.bl, act.bl);
        end
        if (act.br !== exp_f.br) begin
          errors++;
          $display("%0t: bottom_right expected %0d actual %0d", $time, exp_f.br, act.br);
        end
        if (act.en !== exp_f.en) begin
          errors++;
          $display("%0t: enable expected %b actual %b", $time, exp_f.en, act.en);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("flap_attitude_controller_tb failed");
      $finish;
    end
  end

  initial begin
    threshold = 0; az_gain = 0; pt_gain = 0; az_limit = 0;
    gain_x = 0; gain_y = 0; gain_z = 0; top_neutral = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values first: only neutral behavior.
    tick_queue.push_back(make_tick(16384, 0, 0, 0, 500, fac_pkg::MODE_STABILIZE, 1000, 0));
    drain();

    load_setting(0, 256, 256, 32767, 16, 16, 16, 0);
    tick_queue.push_back(make_tick(16384, 0, 0, 0, 0, fac_pkg::MODE_STABILIZE, 0, 0));
    tick_queue.push_back(make_tick(0, 0, 0, 0, 100, fac_pkg::MODE_STABILIZE, 12868, 0));
    tick_queue.push_back(make_tick(-16384, -16384, -16384, -16384, 32767,
                                   fac_pkg::MODE_STABILIZE, -12868, 1));
    tick_queue.push_back(make_tick(16384, 16384, 16384, 16384, -32768,
                                   fac_pkg::MODE_STABILIZE, 12868, 1));
    tick_queue.push_back(make_tick(11585, 0, 11585, 0, 0, fac_pkg::MODE_STABILIZE,
                                   -12868, 0));
    tick_queue.push_back(make_tick(0, 0, 16384, 0, 0, fac_pkg::MODE_STABILIZE, 6434, 0));
    tick_queue.push_back(make_tick(0, 16384, 0, 0, 0, fac_pkg::MODE_STABILIZE, 0, 0));
    tick_queue.push_back(make_tick(0, 0, 0, 16384, 0, fac_pkg::MODE_STABILIZE, 0, 0));
    tick_queue.push_back(make_tick(-32768, 32767, -32768, 32767, 1,
                                   fac_pkg::MODE_STABILIZE, 0, 0));
    tick_queue.push_back(make_tick(3, 0, 0, 0, 0, fac_pkg::MODE_STABILIZE, -16384, 1));
    tick_queue.push_back(make_tick(16384, 0, 0, 0, 0, fac_pkg::MODE_UPRIGHT, 0, 0));
    tick_queue.push_back(make_tick(16384, 0, 0, 0, 0, fac_pkg::MODE_ASCENT, 0, 0));
    tick_queue.push_back(make_tick(16384, 0, 0, 0, 0, fac_pkg::MODE_ASCENT, 0, 1));
    tick_queue.push_back(make_tick(16384, 0, 0, 0, 0, 3, 0, 0));
    tick_queue.push_back(make_tick(16384, 0, 0, 0, 0, 3, 0, 1));
    drain();

    load_setting(12868, 32767, -32768, 0, 32767, -32768, 32767, 12868);
    tick_queue.push_back(make_tick(-16384, 16384, -16384, 16384, 32767,
                                   fac_pkg::MODE_STABILIZE, 12868, 0));
    tick_queue.push_back(make_tick(0, 16384, 0, 0, -32768, fac_pkg::MODE_STABILIZE,
                                   -12868, 0));
    random_phase(120);

    load_setting(0, -32768, 32767, 1000, -32768, 32767, -32768, -12868);
    random_phase(120);

    load_setting(1430, $urandom(), $urandom(), $urandom(), $urandom_range(0, 300),
                 $urandom_range(0, 300), $urandom_range(0, 300), -2000);
    random_phase(120);

    load_setting(16383, 40, -40, 32767, -10, 10, 5, $urandom_range(0, 8000));
    random_phase(120);

    $display("Covered %0d ticks (stabilize %0d, upright %0d, ascent %0d), %0d results,",
             ticks_sent, mode_count[0], mode_count[1], mode_count[2], flaps_seen);
    $display("over five register settings including the extremes.");
    if (errors == 0) begin
      $display("flap_attitude_controller_tb passed");
    end else begin
      $display("flap_attitude_controller_tb failed");
    end
    $finish;
  end

endmodule
